// ===== src/rbmr_pkg.sv =====
package rbmr_pkg;

    localparam int MAX_MSG_LEN = 64;
    localparam int ADDR_W      = $clog2(MAX_MSG_LEN);
    localparam int CNT_W       = $clog2(MAX_MSG_LEN + 1);
    localparam int CMP_W       = (CNT_W > 7) ? CNT_W : 7;

    localparam logic [7:0] CHECK_GOOD  = 8'hFF;
    localparam logic [1:0] LEN_VAR_SEL = 2'b11;

    typedef enum logic [2:0] {
        ST_RECV = 3'b001,
        ST_READ = 3'b010,
        ST_LOAD = 3'b100
    } state_t;

    typedef struct packed {
        logic accept;
        logic rd;
        logic load;
    } cmd_t;

    typedef struct packed {
        logic msg_ok;
        logic out_free;
        logic last_beat;
    } status_t;

endpackage

// ===== src/rbmr_ctrl.sv =====
module rbmr_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  rbmr_pkg::status_t status,
    output rbmr_pkg::cmd_t    cmd
);
    import rbmr_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RECV;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_RECV:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid && status.msg_ok)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (status.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = status.last_beat ? ST_RECV : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_RECV;
            end
        endcase
    end

endmodule

// ===== src/rbmr_dp.sv =====
module rbmr_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        s_tdata,
    input  rbmr_pkg::cmd_t    cmd,
    output rbmr_pkg::status_t status,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,
    output logic              m_tlast
);
    import rbmr_pkg::*;

    logic [7:0]        mem [MAX_MSG_LEN];
    logic [7:0]        rd_data_reg;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [7:0]        xor_reg, xor_next;
    logic              coll_reg, coll_next;
    logic [7:0]        op_reg, op_next;
    logic [6:0]        b1_reg, b1_next;
    logic [CNT_W-1:0]  emit_len_reg, emit_len_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [7:0]        m_tdata_reg;
    logic              m_tlast_reg;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [CNT_W-1:0]  cnt_inc;
    logic [7:0]        xor_inc;
    logic [CMP_W-1:0]  len_cur;
    logic [6:0]        byte1;
    logic              msg_ok;

    always_comb
    begin
        count_next    = count_reg;
        xor_next      = xor_reg;
        coll_next     = coll_reg;
        op_next       = op_reg;
        b1_next       = b1_reg;
        emit_len_next = emit_len_reg;
        wr_en         = 1'b0;
        wr_addr       = count_reg[ADDR_W-1:0];
        msg_ok        = 1'b0;
        cnt_inc       = count_reg + CNT_W'(1);
        xor_inc       = xor_reg ^ s_tdata;
        byte1         = (count_reg == CNT_W'(1)) ? s_tdata[6:0] : b1_reg;
        if (op_reg[6:5] == LEN_VAR_SEL)
        begin
            len_cur = CMP_W'(byte1);
        end
        else
        begin
            len_cur = CMP_W'({op_reg[6:5], 1'b0}) + CMP_W'(2);
        end

        if (cmd.accept)
        begin
            if (s_tdata[7])
            begin
                wr_en      = 1'b1;
                wr_addr    = '0;
                count_next = CNT_W'(1);
                xor_next   = s_tdata;
                coll_next  = 1'b1;
                op_next    = s_tdata;
            end
            else if (coll_reg)
            begin
                count_next = '0;
                xor_next   = '0;
                coll_next  = 1'b0;
                if (CMP_W'(count_reg) < CMP_W'(MAX_MSG_LEN))
                begin
                    wr_en = 1'b1;
                    if (count_reg == CNT_W'(1))
                    begin
                        b1_next = s_tdata[6:0];
                    end
                    if (len_cur <= CMP_W'(MAX_MSG_LEN) && len_cur >= CMP_W'(cnt_inc))
                    begin
                        if (len_cur == CMP_W'(cnt_inc))
                        begin
                            if (xor_inc == CHECK_GOOD)
                            begin
                                msg_ok        = 1'b1;
                                emit_len_next = cnt_inc;
                            end
                        end
                        else
                        begin
                            count_next = cnt_inc;
                            xor_next   = xor_inc;
                            coll_next  = 1'b1;
                        end
                    end
                end
            end
        end
    end

    // emit side
    assign status.msg_ok    = msg_ok;
    assign status.out_free  = !m_tvalid_reg || m_tready;
    assign status.last_beat = (CNT_W'(idx_reg) + CNT_W'(1)) == emit_len_reg;

    always_comb
    begin
        idx_next      = idx_reg;
        m_tvalid_next = m_tvalid_reg;
        if (msg_ok)
        begin
            idx_next = '0;
        end
        else if (cmd.load)
        begin
            idx_next = idx_reg + ADDR_W'(1);
        end
        if (cmd.load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            xor_reg      <= '0;
            coll_reg     <= 1'b0;
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            xor_reg      <= xor_next;
            coll_reg     <= coll_next;
            idx_reg      <= idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        b1_reg       <= b1_next;
        emit_len_reg <= emit_len_next;
        if (cmd.load)
        begin
            m_tdata_reg <= rd_data_reg;
            m_tlast_reg <= status.last_beat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= s_tdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd)
        begin
            rd_data_reg <= mem[idx_reg];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(count_reg) <= CMP_W'(MAX_MSG_LEN))
        else $error("byte count beyond buffer");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (!m_tvalid_reg || m_tready))
        else $error("output overwritten");

    a_ok_closes: assert property (@(posedge clk) disable iff (!rst_n)
        msg_ok |=> (count_reg == '0 && !coll_reg && idx_reg == '0))
        else $error("message not closed after check");
`endif

endmodule

// ===== src/rail_bus_message_receiver.sv =====
// Bus byte receiver: one byte per beat in, checked messages out one byte per beat with tlast
// on the final byte. While no message is being sent, a byte is taken every cycle. When a
// byte completes a message whose XOR is 0xFF, input is held off while the message is read
// back from the 64-byte buffer, each byte by a buffer read and then an output register
// load, which waits while the output side stalls. The last byte may still wait in the
// output register when input opens.
module rail_bus_message_receiver (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] rx_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] msg_byte
    output logic       m_tlast
);
    import rbmr_pkg::*;

    cmd_t    cmd;
    status_t status;

    rbmr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rbmr_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
